>>> src/audio_frame_packer_with_test_tones_assert.svh
// Assertion macros shared by the frame packer modules.
`ifndef AUDIO_FRAME_PACKER_WITH_TEST_TONES_ASSERT_SVH
`define AUDIO_FRAME_PACKER_WITH_TEST_TONES_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that expr holds in the same cycle as cond.
`define AFP_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("afp assertion failed");

// Check that expr holds in the cycle after cond.
`define AFP_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("afp assertion failed");

`else

`define AFP_ASSERT_IMPLY(label, clk, rst, cond, expr)

`define AFP_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

>>> src/afp_pkg.sv
`default_nettype none

package afp_pkg;

   // Mode register codes; code 3 behaves as pass-through
   localparam logic [1:0] MODE_PASS  = 2'd0;
   localparam logic [1:0] MODE_SCALE = 2'd1;
   localparam logic [1:0] MODE_CHIRP = 2'd2;

   // Scale sequencer
   localparam int NOTE_LEN   = 13440;
   localparam int NOTE_TOTAL = 14;

   // Phase step of f Hz is floor(f * 2^22 / 48000) = floor(f * 32768 / 375)
   localparam int STEP_NUM = 32768;
   localparam int STEP_DEN = 375;
   localparam int STEP_INC = STEP_NUM / STEP_DEN;
   localparam int REM_INC  = STEP_NUM % STEP_DEN;

   localparam logic [15:0] NOTE_STEP [NOTE_TOTAL] = '{
      16'(262 * STEP_NUM / STEP_DEN), 16'(294 * STEP_NUM / STEP_DEN),
      16'(330 * STEP_NUM / STEP_DEN), 16'(349 * STEP_NUM / STEP_DEN),
      16'(392 * STEP_NUM / STEP_DEN), 16'(440 * STEP_NUM / STEP_DEN),
      16'(494 * STEP_NUM / STEP_DEN), 16'(523 * STEP_NUM / STEP_DEN),
      16'(494 * STEP_NUM / STEP_DEN), 16'(440 * STEP_NUM / STEP_DEN),
      16'(392 * STEP_NUM / STEP_DEN), 16'(349 * STEP_NUM / STEP_DEN),
      16'(330 * STEP_NUM / STEP_DEN), 16'(294 * STEP_NUM / STEP_DEN)
   };

   // Chirp sweep
   localparam int SWEEP_LEN   = 48000;
   localparam int CHIRP_LOW   = 200;
   localparam int CHIRP_HIGH  = 6000;
   localparam int SWEEP_DELTA = CHIRP_HIGH - CHIRP_LOW;

   localparam logic [19:0] LOW_STEP  = 20'(CHIRP_LOW * STEP_NUM / STEP_DEN);
   localparam logic [8:0]  LOW_REM   = 9'(CHIRP_LOW * STEP_NUM % STEP_DEN);
   localparam logic [19:0] HIGH_STEP = 20'(CHIRP_HIGH * STEP_NUM / STEP_DEN);
   localparam logic [8:0]  HIGH_REM  = 9'(CHIRP_HIGH * STEP_NUM % STEP_DEN);

   // Sweep events seen by both channel lanes
   typedef struct packed {
      logic wrap;  // sweep restarts (rising lane at its low end, falling lane at its high end)
      logic bump;  // chirp frequency moves by one hertz
   } sweep_ctl_type;

   typedef logic signed [15:0] sample_type;

   localparam logic [15:0] QUARTER_WAVE [17] = '{
      16'd0, 16'd1568, 16'd3121, 16'd4645, 16'd6123, 16'd7542, 16'd8889,
      16'd10150, 16'd11314, 16'd12368, 16'd13304, 16'd14111, 16'd14782,
      16'd15311, 16'd15693, 16'd15923, 16'd16000
   };

   // 64-point sine built from the quarter wave
   function automatic sample_type sine_at(input logic [5:0] idx);
      sample_type res;
      if (idx <= 6'd16) begin
         res = sample_type'(QUARTER_WAVE[5'(idx)]);
      end else if (idx < 6'd32) begin
         res = sample_type'(QUARTER_WAVE[5'(6'd32 - idx)]);
      end else if (idx <= 6'd48) begin
         res = -sample_type'(QUARTER_WAVE[5'(idx - 6'd32)]);
      end else begin
         res = -sample_type'(QUARTER_WAVE[5'(7'd64 - {1'b0, idx})]);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> src/afp_scale.sv
`default_nettype none

`include "audio_frame_packer_with_test_tones_assert.svh"

module afp_scale (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   output logic      [5:0] scale_index
);

   logic [21:0] phase_ff, phase_in;
   logic [15:0] step_ff, step_in;
   logic [13:0] count_ff, count_in;
   logic [3:0]  index_ff, index_in;
   logic [3:0]  index_eff;
   logic [15:0] step_eff;
   logic [21:0] phase_eff;
   logic        first;

   // Pick the note and restart the phase at the start of each note
   always_comb begin
      index_eff = (index_ff >= 4'(afp_pkg::NOTE_TOTAL)) ? '0 : index_ff;
      first     = (count_ff == '0);
      step_eff  = first ? afp_pkg::NOTE_STEP[index_eff] : step_ff;
      phase_eff = first ? '0 : phase_ff;
      scale_index = phase_eff[21:16];
   end

   // Advance phase, sample count and note
   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      count_in = count_ff;
      index_in = index_ff;
      if (advance) begin
         phase_in = phase_eff + {6'b0, step_eff};
         step_in  = step_eff;
         index_in = index_eff;
         if (count_ff >= 14'(afp_pkg::NOTE_LEN - 1)) begin
            count_in = '0;
            index_in = (index_eff == 4'(afp_pkg::NOTE_TOTAL - 1)) ? '0 : index_eff + 4'd1;
         end else begin
            count_in = count_ff + 14'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         step_ff  <= '0;
         count_ff <= '0;
         index_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

   `AFP_ASSERT_IMPLY(a_count_range, clock, reset, 1'b1,
      count_ff < 14'(afp_pkg::NOTE_LEN))
   `AFP_ASSERT_IMPLY(a_index_range, clock, reset, 1'b1,
      index_ff < 4'(afp_pkg::NOTE_TOTAL))
   `AFP_ASSERT_NEXT(a_note_end, clock, reset,
      advance && count_ff == 14'(afp_pkg::NOTE_LEN - 1), count_ff == '0)

endmodule

`default_nettype wire

>>> src/afp_sweep.sv
`default_nettype none

module afp_sweep (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   output afp_pkg::sweep_ctl_type     sweep_ctl
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] rem_ff, rem_in;
   logic [16:0] rem_sum;

   // Track 5800 * pos mod 48000; a carry moves both chirp tones by 1 Hz
   always_comb begin
      rem_sum        = {1'b0, rem_ff} + 17'(afp_pkg::SWEEP_DELTA);
      sweep_ctl.wrap = (pos_ff >= 16'(afp_pkg::SWEEP_LEN - 1));
      sweep_ctl.bump = (rem_sum >= 17'(afp_pkg::SWEEP_LEN));
      pos_in = pos_ff;
      rem_in = rem_ff;
      if (advance) begin
         if (sweep_ctl.wrap) begin
            pos_in = '0;
            rem_in = '0;
         end else begin
            pos_in = pos_ff + 16'd1;
            rem_in = sweep_ctl.bump ? 16'(rem_sum - 17'(afp_pkg::SWEEP_LEN)) : 16'(rem_sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         rem_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         rem_ff <= rem_in;
      end
   end

endmodule

`default_nettype wire

>>> src/afp_lane.sv
`default_nettype none

module afp_lane (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic [1:0]             mode,
   input  wire logic                   sample_valid,
   input  wire afp_pkg::sample_type    sample_in,
   input  wire logic [5:0]             scale_index,
   input  wire afp_pkg::sweep_ctl_type sweep_ctl,
   input  wire logic                   falling,
   output afp_pkg::sample_type         sample_out
);

   afp_pkg::sample_type held_ff, held_in;
   logic [21:0]         phase_ff, phase_in;
   logic [19:0]         step_ff, step_in;
   logic [8:0]          rem_ff, rem_in;
   afp_pkg::sample_type fade_val;
   logic [9:0]          rem_up;
   logic                is_pass;

   // Select this channel's sample
   always_comb begin
      fade_val = held_ff - (held_ff >>> 6);
      is_pass  = (mode != afp_pkg::MODE_SCALE) && (mode != afp_pkg::MODE_CHIRP);
      case (mode)
         afp_pkg::MODE_SCALE: sample_out = afp_pkg::sine_at(scale_index);
         afp_pkg::MODE_CHIRP: sample_out = afp_pkg::sine_at(phase_ff[21:16]);
         default:             sample_out = sample_valid ? sample_in : fade_val;
      endcase
   end

   // Hold the last pass-through or faded sample
   always_comb begin
      held_in = held_ff;
      if (advance && is_pass) begin
         held_in = sample_out;
      end
   end

   // Advance chirp phase, reload the start step on a sweep wrap and move the step by one hertz on each sweep carry
   always_comb begin
      rem_up   = {1'b0, rem_ff} + 10'(afp_pkg::REM_INC);
      phase_in = phase_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      if (advance && mode == afp_pkg::MODE_CHIRP) begin
         phase_in = phase_ff + {2'b0, step_ff};
         if (sweep_ctl.wrap) begin
            step_in = falling ? afp_pkg::HIGH_STEP : afp_pkg::LOW_STEP;
            rem_in  = falling ? afp_pkg::HIGH_REM : afp_pkg::LOW_REM;
         end else if (sweep_ctl.bump) begin
            if (falling) begin
               if (rem_ff < 9'(afp_pkg::REM_INC)) begin
                  rem_in  = rem_ff + 9'(afp_pkg::STEP_DEN - afp_pkg::REM_INC);
                  step_in = step_ff - 20'(afp_pkg::STEP_INC + 1);
               end else begin
                  rem_in  = rem_ff - 9'(afp_pkg::REM_INC);
                  step_in = step_ff - 20'(afp_pkg::STEP_INC);
               end
            end else begin
               if (rem_up >= 10'(afp_pkg::STEP_DEN)) begin
                  rem_in  = 9'(rem_up - 10'(afp_pkg::STEP_DEN));
                  step_in = step_ff + 20'(afp_pkg::STEP_INC + 1);
               end else begin
                  rem_in  = 9'(rem_up);
                  step_in = step_ff + 20'(afp_pkg::STEP_INC);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= '0;
         phase_ff <= '0;
         step_ff  <= falling ? afp_pkg::HIGH_STEP : afp_pkg::LOW_STEP;
         rem_ff   <= falling ? afp_pkg::HIGH_REM : afp_pkg::LOW_REM;
      end else begin
         held_ff  <= held_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
         rem_ff   <= rem_in;
      end
   end

endmodule

`default_nettype wire

>>> src/audio_frame_packer_with_test_tones.sv
// Channel   Direction  Handshake             Contents
// req       in         req_tvalid/tready     tdata: left, right; tuser: valid, clear_peak
// rsp       out        rsp_tvalid/tready     tdata: left_word, right_word, peak_level
// csr       in         csr_wen               csr_wdata: signal_mode
//
// One frame per clock while req_tready is high; results leave from the output register.
// Left and right lanes compute their samples side by side and the merge stage
// folds both into the peak tracker in the same cycle.
// A two-entry output stage (register plus skid) keeps taking frames after rsp
// stalls until the skid entry fills; req_tready drops only while the skid entry is full.
// Synchronous reset clears fade and peak state and the mode register; tones restart.
`default_nettype none

`include "audio_frame_packer_with_test_tones_assert.svh"

module audio_frame_packer_with_test_tones (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // left_sample[15:0], right_sample[31:16]
   input  wire logic [1:0]  req_tuser,   // sample_valid[0], clear_peak[1]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // left_word[27:0], right_word[55:28], peak_level[71:56]
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_wdata
);

   logic [1:0]             mode_ff;
   logic                   accept;
   logic [5:0]             scale_index;
   afp_pkg::sweep_ctl_type sweep_ctl;
   afp_pkg::sample_type    left_val, right_val;
   logic [15:0]            peak_ff, peak_in;
   logic [15:0]            peak_base, peak_mid, abs_left, abs_right;
   logic                   counted;
   logic [71:0]            item;
   logic [71:0]            rsp_data_ff, rsp_data_in;
   logic [71:0]            skid_data_ff, skid_data_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   skid_valid_ff, skid_valid_in;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Hold the mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= afp_pkg::MODE_PASS;
      end else if (csr_wen) begin
         mode_ff <= csr_wdata;
      end
   end

   afp_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept && mode_ff == afp_pkg::MODE_SCALE),
      .scale_index (scale_index)
   );

   afp_sweep u_sweep (
      .clock     (clock),
      .reset     (reset),
      .advance   (accept && mode_ff == afp_pkg::MODE_CHIRP),
      .sweep_ctl (sweep_ctl)
   );

   afp_lane u_lane_left (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .mode         (mode_ff),
      .sample_valid (req_tuser[0]),
      .sample_in    (afp_pkg::sample_type'(req_tdata[15:0])),
      .scale_index  (scale_index),
      .sweep_ctl    (sweep_ctl),
      .falling      (1'b0),
      .sample_out   (left_val)
   );

   afp_lane u_lane_right (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .mode         (mode_ff),
      .sample_valid (req_tuser[0]),
      .sample_in    (afp_pkg::sample_type'(req_tdata[31:16])),
      .scale_index  (scale_index),
      .sweep_ctl    (sweep_ctl),
      .falling      (1'b1),
      .sample_out   (right_val)
   );

   // Merge lanes: clear, then fold both magnitudes into the peak
   always_comb begin
      counted   = (mode_ff == afp_pkg::MODE_SCALE) || (mode_ff == afp_pkg::MODE_CHIRP) ||
                  req_tuser[0];
      abs_left  = left_val[15] ? 16'(-left_val) : 16'(left_val);
      abs_right = right_val[15] ? 16'(-right_val) : 16'(right_val);
      peak_base = req_tuser[1] ? '0 : peak_ff;
      peak_mid  = (counted && abs_left > peak_base) ? abs_left : peak_base;
      peak_in   = (counted && abs_right > peak_mid) ? abs_right : peak_mid;
      item      = {peak_in, 16'(right_val), 12'b0, 16'(left_val), 12'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
      end else if (accept) begin
         peak_ff <= peak_in;
      end
   end

   // Output register with skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = accept;
            rsp_data_in  = item;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   `AFP_ASSERT_IMPLY(a_skid_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff)
   `AFP_ASSERT_NEXT(a_stall_fills_skid, clock, reset,
      accept && rsp_valid_ff && !rsp_tready, skid_valid_ff)
   `AFP_ASSERT_IMPLY(a_peak_range, clock, reset, 1'b1, peak_ff <= 16'h8000)

endmodule

`default_nettype wire
